### rtl/core/hqfk_pkg.sv
package hqfk_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int POLY_W = 44;
    localparam int N_DIV = 6;

    localparam logic signed [POLY_W-1:0] FIX_ONE = POLY_W'(64'h1_0000_0000);
    localparam logic signed [POLY_W-1:0] K2  = POLY_W'(2);
    localparam logic signed [POLY_W-1:0] K6  = POLY_W'(6);
    localparam logic signed [POLY_W-1:0] K18 = POLY_W'(18);
    localparam logic signed [POLY_W-1:0] K19 = POLY_W'(19);
    localparam logic signed [POLY_W-1:0] K21 = POLY_W'(21);
    localparam logic signed [POLY_W-1:0] K36 = POLY_W'(36);
    localparam logic signed [POLY_W-1:0] K68 = POLY_W'(68);
    localparam logic signed [POLY_W-1:0] K74 = POLY_W'(74);

    typedef struct packed {
        logic valid;
        logic kill;
        logic sat;
    } t_ctl;

    // Partial products of a signed value times an unsigned Q0.32 fraction.
    typedef struct packed {
        logic              neg;
        logic [POLY_W-1:0] hi;
        logic [31:0]       lo;
    } t_mfp;

    function automatic logic [31:0] fmul(input logic [31:0] x, input logic [31:0] y);
        logic [63:0] p;
        p = {32'b0, x} * {32'b0, y};
        return p[63:32];
    endfunction

    function automatic t_mfp mf_part(input logic signed [POLY_W-1:0] x,
                                     input logic [31:0] f);
        t_mfp        p;
        logic [POLY_W-1:0] m;
        logic [63:0] lp;
        p.neg = x[POLY_W-1];
        m = x[POLY_W-1] ? (~x + POLY_W'(1)) : x;
        p.hi = {32'b0, m[POLY_W-1:32]} * {{(POLY_W-32){1'b0}}, f};
        lp = {32'b0, m[31:0]} * {32'b0, f};
        p.lo = lp[63:32];
        return p;
    endfunction

    function automatic logic signed [POLY_W-1:0] mf_sum(input t_mfp p);
        logic [POLY_W-1:0] s;
        s = p.hi + {{(POLY_W-32){1'b0}}, p.lo};
        return p.neg ? signed'(~s + POLY_W'(1)) : signed'(s);
    endfunction

endpackage

### rtl/core/hqfk_front.sv
module hqfk_front
    import hqfk_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [15:0]       i_z_frac,
    input  logic [15:0]       i_r_ratio,
    output t_ctl              o_ctl,
    output logic [POLY_W-1:0] o_val,
    output logic [32:0]       o_a
);

    localparam int NS = 15;

    typedef struct packed {
        t_ctl                     ctl;
        logic [31:0]              z;
        logic [31:0]              r;
        logic [31:0]              om;
        logic [31:0]              omz;
        logic [31:0]              r2;
        logic [31:0]              om2;
        logic [31:0]              rz;
        logic [31:0]              omz2;
        logic [31:0]              num;
        logic [32:0]              a;
        logic signed [POLY_W-1:0] c1;
        logic signed [POLY_W-1:0] c2;
        logic signed [POLY_W-1:0] c3;
        logic signed [POLY_W-1:0] c4;
        logic signed [POLY_W-1:0] q3;
        logic signed [POLY_W-1:0] q4;
        logic signed [POLY_W-1:0] poly;
        t_mfp                     mp1;
        t_mfp                     mp2;
        logic [POLY_W-1:0]        val;
    } t_fe;

    t_fe r_st [1:NS];
    t_fe n_st [1:NS];

    always_comb begin
        logic [31:0] zx;
        logic [31:0] rx;
        logic signed [POLY_W-1:0] rs;
        logic signed [POLY_W-1:0] r2s;
        logic signed [POLY_W-1:0] s1;
        logic signed [POLY_W-1:0] s2;

        zx = {16'b0, i_z_frac};
        rx = {16'b0, i_r_ratio};

        n_st[1] = '0;
        n_st[1].ctl.valid = i_valid;
        n_st[1].ctl.kill = (i_z_frac == 16'd0) || ((zx >> FRAC_BITS) != 32'd0)
                        || (i_r_ratio == 16'd0) || ((rx >> FRAC_BITS) != 32'd0);
        n_st[1].z = zx << (32 - FRAC_BITS);
        n_st[1].r = rx << (32 - FRAC_BITS);
        n_st[1].om = 32'(33'h1_0000_0000 - {1'b0, n_st[1].r});
        n_st[1].omz = 32'(33'h1_0000_0000 - {1'b0, n_st[1].z});

        for (int k = 2; k <= NS; k++) begin
            n_st[k] = r_st[k-1];
        end

        n_st[2].r2 = fmul(r_st[1].r, r_st[1].r);
        n_st[2].om2 = fmul(r_st[1].om, r_st[1].om);
        n_st[2].rz = fmul(r_st[1].r, r_st[1].z);
        n_st[2].omz2 = fmul(r_st[1].omz, r_st[1].omz);
        n_st[2].a = 33'h1_0000_0000 - {1'b0, fmul(r_st[1].om, r_st[1].z)};

        rs = signed'(POLY_W'(r_st[2].r));
        r2s = signed'(POLY_W'(r_st[2].r2));
        n_st[3].c1 = K36 * rs - K18 * FIX_ONE;
        n_st[3].c2 = K21 * FIX_ONE - K74 * rs + K68 * r2s;
        n_st[3].q3 = K6 * FIX_ONE - K19 * rs + K18 * r2s;
        n_st[3].q4 = FIX_ONE - K2 * rs + K2 * r2s;
        n_st[3].num = fmul(r_st[2].rz, r_st[2].omz2);

        n_st[4].mp1 = mf_part(r_st[3].q3, r_st[3].om);
        n_st[4].mp2 = mf_part(r_st[3].q4, r_st[3].om2);

        s1 = mf_sum(r_st[4].mp1);
        s2 = mf_sum(r_st[4].mp2);
        n_st[5].c3 = -(s1 <<< 1);
        n_st[5].c4 = s2 + (s2 <<< 1);

        // Horner's rule in z, one multiply and one add per pair of stages.
        n_st[6].mp1 = mf_part(r_st[5].c4, r_st[5].z);
        n_st[7].poly = r_st[6].c3 + mf_sum(r_st[6].mp1);
        n_st[8].mp1 = mf_part(r_st[7].poly, r_st[7].z);
        n_st[9].poly = r_st[8].c2 + mf_sum(r_st[8].mp1);
        n_st[10].mp1 = mf_part(r_st[9].poly, r_st[9].z);
        n_st[11].poly = r_st[10].c1 + mf_sum(r_st[10].mp1);
        n_st[12].mp1 = mf_part(r_st[11].poly, r_st[11].z);
        n_st[13].poly = K6 * FIX_ONE + mf_sum(r_st[12].mp1);

        n_st[14].ctl.kill = r_st[13].ctl.kill || r_st[13].poly[POLY_W-1]
                         || (r_st[13].poly == '0);
        n_st[14].mp1 = mf_part(r_st[13].poly, r_st[13].num);

        n_st[15].val = unsigned'(mf_sum(r_st[14].mp1));

        if (!i_rst_n) begin
            for (int k = 1; k <= NS; k++) begin
                n_st[k].ctl.valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
    end

    assign o_ctl = r_st[NS].ctl;
    assign o_val = r_st[NS].val;
    assign o_a = r_st[NS].a;

endmodule

### rtl/core/hqfk_div_cell.sv
module hqfk_div_cell
    import hqfk_pkg::*;
#(
    parameter int VW = 49
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [31:0]   i_rem,
    input  logic [VW-1:0] i_w,
    input  logic [32:0]   i_a,
    output t_ctl          o_ctl,
    output logic [31:0]   o_rem,
    output logic [VW-1:0] o_w,
    output logic [32:0]   o_a
);

    logic [32:0] t;
    logic        ge;
    logic [32:0] diff;
    t_ctl        n_ctl;
    t_ctl        r_ctl;
    logic [31:0] r_rem;
    logic [VW-1:0] r_w;
    logic [32:0] r_a;

    // One restoring step: the next dividend bit comes off the top of w and
    // the quotient bit goes in at the bottom.
    assign t = {i_rem, i_w[VW-1]};
    assign ge = (t >= i_a);
    assign diff = t - i_a;

    always_comb begin
        n_ctl = i_ctl;
        // The remainder is below the divisor except at the head of a division,
        // where one that is not below it means the quotient overflows.
        n_ctl.sat = i_ctl.sat || ({1'b0, i_rem} >= i_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= n_ctl.valid;
        end
        r_ctl.kill <= n_ctl.kill;
        r_ctl.sat <= n_ctl.sat;
        r_rem <= ge ? diff[31:0] : t[31:0];
        r_w <= {i_w[VW-2:0], ge};
        r_a <= i_a;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_w = r_w;
    assign o_a = r_a;

endmodule

### rtl/core/hq_fragmentation_kernel_core.sv
// Heavy-quark fragmentation kernel, one evaluation per clock.
// Input: drive i_z_frac and i_r_ratio with start high; a word is taken at
// every rising edge where start is high and busy is low. busy is always low,
// so a new word may be given in every cycle.
// Output: o_valid is high for exactly one cycle with o_kernel_value (Q16.16
// at the default FRAC_BITS) and o_saturated. The receiver cannot stall the
// block and must take each word in the cycle it appears.
// From acceptance to o_valid, fifteen stages form the polynomial and the
// numerator; then six divisions by a run through a row of one-bit divider
// cells, 65-FRAC_BITS cells per division, and a last register drives the
// outputs.
// Throughput: one word per cycle; every cell steps each cycle.
// Results leave in the order the words were taken.
// Reset clears all valid flags; words in flight are dropped and o_valid
// stays low until a word accepted after reset reaches the end.
module hq_fragmentation_kernel_core
    import hqfk_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_z_frac,
    input  logic [15:0] i_r_ratio,
    output logic        o_valid,
    output logic [31:0] o_kernel_value,
    output logic        o_saturated
);

    localparam int VW = 65 - FRAC_BITS;
    localparam int NC = N_DIV * VW;

    t_ctl              fe_ctl;
    logic [POLY_W-1:0] fe_val;
    logic [32:0]       fe_a;
    logic [63:0]       val64;

    t_ctl          c_ctl [0:NC-1];
    logic [31:0]   c_rem [0:NC-1];
    logic [VW-1:0] c_w   [0:NC-1];
    logic [32:0]   c_a   [0:NC-1];

    t_ctl          g_ctl [0:N_DIV-1];
    logic [31:0]   g_rem [0:N_DIV-1];
    logic [VW-1:0] g_w   [0:N_DIV-1];
    logic [32:0]   g_a   [0:N_DIV-1];
    logic [VW-1:0] g_v   [0:N_DIV-1];

    logic          r_valid;
    logic [31:0]   r_kernel_value;
    logic          r_saturated;
    t_ctl          last_ctl;
    logic [VW-1:0] last_w;

    assign busy = 1'b0;

    hqfk_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_z_frac (i_z_frac),
        .i_r_ratio(i_r_ratio),
        .o_ctl    (fe_ctl),
        .o_val    (fe_val),
        .o_a      (fe_a)
    );

    assign val64 = {{(64-POLY_W){1'b0}}, fe_val};

    genvar d, j;
    generate
        for (d = 0; d < N_DIV; d++) begin : g_div
            // Split the running value into the leading remainder and the
            // bits still to be shifted in, the latter followed by 32 zero bits.
            if (d == 0) begin : g_head0
                always_comb begin
                    g_v[d] = val64[VW-1:0];
                    g_ctl[d] = fe_ctl;
                    g_ctl[d].sat = fe_ctl.sat || ((val64 >> (VW - 1)) != 64'd0);
                end
                assign g_a[d] = fe_a;
            end else begin : g_headn
                always_comb begin
                    g_v[d] = c_w[d*VW-1];
                    g_ctl[d] = c_ctl[d*VW-1];
                    g_ctl[d].sat = c_ctl[d*VW-1].sat || c_w[d*VW-1][VW-1];
                end
                assign g_a[d] = c_a[d*VW-1];
            end
            assign g_rem[d] = {1'b0, g_v[d][VW-2:VW-32]};
            assign g_w[d] = {g_v[d][VW-33:0], 32'b0};

            for (j = 0; j < VW; j++) begin : g_cell
                if (j == 0) begin : g_first
                    hqfk_div_cell #(
                        .VW(VW)
                    ) u_cell (
                        .i_clk  (i_clk),
                        .i_rst_n(i_rst_n),
                        .i_ctl  (g_ctl[d]),
                        .i_rem  (g_rem[d]),
                        .i_w    (g_w[d]),
                        .i_a    (g_a[d]),
                        .o_ctl  (c_ctl[d*VW+j]),
                        .o_rem  (c_rem[d*VW+j]),
                        .o_w    (c_w[d*VW+j]),
                        .o_a    (c_a[d*VW+j])
                    );
                end else begin : g_next
                    hqfk_div_cell #(
                        .VW(VW)
                    ) u_cell (
                        .i_clk  (i_clk),
                        .i_rst_n(i_rst_n),
                        .i_ctl  (c_ctl[d*VW+j-1]),
                        .i_rem  (c_rem[d*VW+j-1]),
                        .i_w    (c_w[d*VW+j-1]),
                        .i_a    (c_a[d*VW+j-1]),
                        .o_ctl  (c_ctl[d*VW+j]),
                        .o_rem  (c_rem[d*VW+j]),
                        .o_w    (c_w[d*VW+j]),
                        .o_a    (c_a[d*VW+j])
                    );
                end
            end
        end
    endgenerate

    assign last_ctl = c_ctl[NC-1];
    assign last_w = c_w[NC-1];

    // A rejected input or a non-positive polynomial wins over overflow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= last_ctl.valid;
        end
        if (last_ctl.kill) begin
            r_kernel_value <= 32'd0;
            r_saturated <= 1'b0;
        end else if (last_ctl.sat || last_w[VW-1]) begin
            r_kernel_value <= 32'hFFFF_FFFF;
            r_saturated <= 1'b1;
        end else begin
            r_kernel_value <= last_w[VW-2:VW-33];
            r_saturated <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_kernel_value = r_kernel_value;
    assign o_saturated = r_saturated;

endmodule
